// ===== design/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// TLV stream parser package
// Shared constants, byte kind and error codes, and the queue entry type
// passed between the front end and the parse engine.
// ----------------------------------------------------------------------------
package tsp_pkg;

    // Limits on header size.
    localparam int MAX_TAG_EXT_BYTES = 4;
    localparam int MAX_LENGTH_BYTES  = 4;

    // Counter widths follow from the limits above.
    localparam int TAG_CNT_W = $clog2(MAX_TAG_EXT_BYTES + 1);
    localparam int LEN_CNT_W = $clog2(MAX_LENGTH_BYTES + 1);

    // Field widths of the result transaction.
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int CLASS_W = 3;
    localparam int TAG_W   = 28;
    localparam int LEN_W   = 32;
    localparam int ERR_W   = 2;

    // Queue between the front end and the parse engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Byte kind codes.
    localparam logic [KIND_W-1:0] KIND_TAG     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LENGTH  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VALUE   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DISCARD = 2'd3;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TAG_LONG  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_LEN_LONG  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED = 2'd3;

    // One classified byte as it sits in the queue.
    typedef struct packed {
        logic [BYTE_W-1:0] data;        // raw byte
        logic              last;        // last byte of the buffer
        logic              stop_bit;    // bit 7: stop on tag, long form on length
        logic              long_tag;    // bit 4: tag number continues in more bytes
        logic              count_zero;  // low seven bits are zero
        logic              count_over;  // low seven bits exceed the length byte limit
    } item_t;

endpackage

// ===== design/tsp_in_if.sv =====
// ----------------------------------------------------------------------------
// TLV stream parser input channel
// Valid/ready channel carrying one raw byte and the end-of-buffer mark.
// ----------------------------------------------------------------------------
interface tsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

// ===== design/tsp_out_if.sv =====
// ----------------------------------------------------------------------------
// TLV stream parser output channel
// Valid/ready channel carrying one labeled byte with its header results.
// ----------------------------------------------------------------------------
interface tsp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic [1:0]  byte_kind;
    logic        header_done;
    logic [2:0]  tag_class;
    logic [27:0] tag_number;
    logic [31:0] value_length;
    logic        record_end;
    logic [1:0]  error_code;

    modport source (
        output valid, output byte_out, output byte_kind, output header_done,
        output tag_class, output tag_number, output value_length,
        output record_end, output error_code, input ready
    );
    modport sink (
        input valid, input byte_out, input byte_kind, input header_done,
        input tag_class, input tag_number, input value_length,
        input record_end, input error_code, output ready
    );
endinterface

// ===== design/tsp_front.sv =====
// ----------------------------------------------------------------------------
// TLV stream parser front end
// Accepts raw bytes, classifies their header bits and holds them in a short
// queue until the parse engine takes them.
// ----------------------------------------------------------------------------
module tsp_front (
    input  logic            clk,
    input  logic            rst_n,
    tsp_in_if.sink          in_ch,
    output logic            q_valid,
    output tsp_pkg::item_t  q_item,
    input  logic            q_ready
);

    tsp_pkg::item_t                       queue_mem [tsp_pkg::QUEUE_DEPTH];
    tsp_pkg::item_t                       cls_item;
    logic [tsp_pkg::QUEUE_IDX_W-1:0]      wr_ptr_reg;
    logic [tsp_pkg::QUEUE_IDX_W-1:0]      wr_ptr_next;
    logic [tsp_pkg::QUEUE_IDX_W-1:0]      rd_ptr_reg;
    logic [tsp_pkg::QUEUE_IDX_W-1:0]      rd_ptr_next;
    logic [tsp_pkg::QUEUE_CNT_W-1:0]      count_reg;
    logic [tsp_pkg::QUEUE_CNT_W-1:0]      count_next;
    logic                                 push;
    logic                                 pop;

    // Classify the incoming byte.
    always_comb
    begin
        cls_item.data       = in_ch.data_byte;
        cls_item.last       = in_ch.buffer_end;
        cls_item.stop_bit   = in_ch.data_byte[7];
        cls_item.long_tag   = in_ch.data_byte[4];
        cls_item.count_zero = (in_ch.data_byte[6:0] == 7'd0);
        cls_item.count_over = (in_ch.data_byte[6:0] > 7'(tsp_pkg::MAX_LENGTH_BYTES));
    end

    // Handshakes on both sides of the queue.
    assign in_ch.ready = (count_reg != tsp_pkg::QUEUE_CNT_W'(tsp_pkg::QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (count_reg != '0);
    assign pop         = q_valid && q_ready;
    assign q_item      = queue_mem[rd_ptr_reg];

    // Pointer and fill count update with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == tsp_pkg::QUEUE_IDX_W'(tsp_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            if (rd_ptr_reg == tsp_pkg::QUEUE_IDX_W'(tsp_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            queue_mem[wr_ptr_reg] <= cls_item;
    end

    // The fill count never passes the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tsp_pkg::QUEUE_CNT_W'(tsp_pkg::QUEUE_DEPTH))
        else $error("queue fill count exceeds depth");

    // A pop without a push lowers the fill count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue fill count did not drop on pop");

endmodule

// ===== design/tsp_back.sv =====
// ----------------------------------------------------------------------------
// TLV stream parser engine
// Walks the tag, length and value phases of each record, one queued byte per
// cycle unless the output channel stalls, and registers each labeled result.
// ----------------------------------------------------------------------------
module tsp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  tsp_pkg::item_t  q_item,
    output logic            q_ready,
    tsp_out_if.source       out_ch
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TAG_EXT,
        PH_LEN_FIRST,
        PH_LEN_EXT,
        PH_VALUE,
        PH_DISCARD
    } phase_t;

    phase_t                               phase_reg;
    phase_t                               phase_next;
    logic [tsp_pkg::TAG_W-1:0]            tag_acc_reg;
    logic [tsp_pkg::TAG_W-1:0]            tag_acc_next;
    logic [tsp_pkg::TAG_CNT_W-1:0]        tag_cnt_reg;
    logic [tsp_pkg::TAG_CNT_W-1:0]        tag_cnt_next;
    logic [tsp_pkg::CLASS_W-1:0]          class_reg;
    logic [tsp_pkg::CLASS_W-1:0]          class_next;
    logic [tsp_pkg::LEN_CNT_W-1:0]        len_left_reg;
    logic [tsp_pkg::LEN_CNT_W-1:0]        len_left_next;
    logic [tsp_pkg::LEN_W-1:0]            len_acc_reg;
    logic [tsp_pkg::LEN_W-1:0]            len_acc_next;
    logic [tsp_pkg::LEN_W-1:0]            val_left_reg;
    logic [tsp_pkg::LEN_W-1:0]            val_left_next;

    logic                                 out_valid_reg;
    logic [tsp_pkg::BYTE_W-1:0]           out_byte_reg;
    logic [tsp_pkg::KIND_W-1:0]           out_kind_reg;
    logic [tsp_pkg::KIND_W-1:0]           kind_next;
    logic                                 out_hdr_reg;
    logic                                 hdr_next;
    logic [tsp_pkg::CLASS_W-1:0]          out_class_reg;
    logic [tsp_pkg::CLASS_W-1:0]          out_class_next;
    logic [tsp_pkg::TAG_W-1:0]            out_tag_reg;
    logic [tsp_pkg::TAG_W-1:0]            tnum_next;
    logic [tsp_pkg::LEN_W-1:0]            out_len_reg;
    logic [tsp_pkg::LEN_W-1:0]            vlen_next;
    logic                                 out_rend_reg;
    logic                                 rend_next;
    logic [tsp_pkg::ERR_W-1:0]            out_err_reg;
    logic [tsp_pkg::ERR_W-1:0]            err_next;

    logic                                 pop;

    // A queued byte moves on whenever the output register is free or drains.
    assign q_ready = !out_valid_reg || out_ch.ready;
    assign pop     = q_valid && q_ready;

    // Phase logic for one byte.
    always_comb
    begin
        logic header_now;
        logic [tsp_pkg::LEN_CNT_W-1:0] len_dec;
        logic [tsp_pkg::LEN_W-1:0]     val_dec;

        header_now    = 1'b0;
        phase_next    = phase_reg;
        tag_acc_next  = tag_acc_reg;
        tag_cnt_next  = tag_cnt_reg;
        class_next    = class_reg;
        len_left_next = len_left_reg;
        len_acc_next  = len_acc_reg;
        val_left_next = val_left_reg;
        kind_next     = tsp_pkg::KIND_DISCARD;
        hdr_next      = 1'b0;
        tnum_next     = '0;
        vlen_next     = '0;
        rend_next     = 1'b0;
        err_next      = tsp_pkg::ERR_NONE;
        len_dec       = (len_left_reg != '0) ? len_left_reg - 1'b1 : '0;
        val_dec       = (val_left_reg != '0) ? val_left_reg - 1'b1 : '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                kind_next  = tsp_pkg::KIND_TAG;
                class_next = q_item.data[7:5];
                if (!q_item.long_tag)
                begin
                    tag_acc_next = {{(tsp_pkg::TAG_W - 4){1'b0}}, q_item.data[3:0]};
                    phase_next   = PH_LEN_FIRST;
                end
                else
                begin
                    tag_acc_next = '0;
                    tag_cnt_next = '0;
                    phase_next   = PH_TAG_EXT;
                end
            end
            PH_TAG_EXT:
            begin
                kind_next    = tsp_pkg::KIND_TAG;
                tag_acc_next = {tag_acc_reg[tsp_pkg::TAG_W-8:0], q_item.data[6:0]};
                tag_cnt_next = tag_cnt_reg + 1'b1;
                if (q_item.stop_bit)
                    phase_next = PH_LEN_FIRST;
                else if (tag_cnt_next >= tsp_pkg::TAG_CNT_W'(tsp_pkg::MAX_TAG_EXT_BYTES))
                begin
                    err_next   = tsp_pkg::ERR_TAG_LONG;
                    phase_next = PH_DISCARD;
                end
            end
            PH_LEN_FIRST:
            begin
                kind_next = tsp_pkg::KIND_LENGTH;
                if (!q_item.stop_bit)
                begin
                    len_acc_next = {{(tsp_pkg::LEN_W - 8){1'b0}}, q_item.data};
                    header_now   = 1'b1;
                end
                else if (q_item.count_zero)
                begin
                    len_acc_next = '0;
                    header_now   = 1'b1;
                end
                else if (q_item.count_over)
                begin
                    err_next   = tsp_pkg::ERR_LEN_LONG;
                    phase_next = PH_DISCARD;
                end
                else
                begin
                    len_acc_next  = '0;
                    len_left_next = q_item.data[tsp_pkg::LEN_CNT_W-1:0];
                    phase_next    = PH_LEN_EXT;
                end
            end
            PH_LEN_EXT:
            begin
                kind_next     = tsp_pkg::KIND_LENGTH;
                len_acc_next  = {len_acc_reg[tsp_pkg::LEN_W-9:0], q_item.data};
                len_left_next = len_dec;
                if (len_dec == '0)
                    header_now = 1'b1;
            end
            PH_VALUE:
            begin
                kind_next     = tsp_pkg::KIND_VALUE;
                val_left_next = val_dec;
                if (val_dec == '0)
                begin
                    rend_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                kind_next = tsp_pkg::KIND_DISCARD;
            end
        endcase

        // Header complete: report the tag and length, then start the value or end an empty record.
        if (header_now)
        begin
            hdr_next  = 1'b1;
            tnum_next = tag_acc_next;
            vlen_next = len_acc_next;
            if (len_acc_next == '0)
            begin
                rend_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            else
            begin
                val_left_next = len_acc_next;
                phase_next    = PH_VALUE;
            end
        end

        out_class_next = (kind_next == tsp_pkg::KIND_DISCARD) ? '0 : class_next;

        // End of buffer: flag an unfinished record and return to idle.
        if (q_item.last)
        begin
            if (err_next == tsp_pkg::ERR_NONE && phase_next != PH_IDLE
                && phase_next != PH_DISCARD)
                err_next = tsp_pkg::ERR_TRUNCATED;
            phase_next    = PH_IDLE;
            tag_acc_next  = '0;
            tag_cnt_next  = '0;
            class_next    = '0;
            len_left_next = '0;
            len_acc_next  = '0;
            val_left_next = '0;
        end
    end

    // Parse state and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tag_acc_reg   <= '0;
            tag_cnt_reg   <= '0;
            class_reg     <= '0;
            len_left_reg  <= '0;
            len_acc_reg   <= '0;
            val_left_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_kind_reg  <= tsp_pkg::KIND_TAG;
            out_hdr_reg   <= 1'b0;
            out_class_reg <= '0;
            out_tag_reg   <= '0;
            out_len_reg   <= '0;
            out_rend_reg  <= 1'b0;
            out_err_reg   <= tsp_pkg::ERR_NONE;
        end
        else
        begin
            if (pop)
            begin
                phase_reg     <= phase_next;
                tag_acc_reg   <= tag_acc_next;
                tag_cnt_reg   <= tag_cnt_next;
                class_reg     <= class_next;
                len_left_reg  <= len_left_next;
                len_acc_reg   <= len_acc_next;
                val_left_reg  <= val_left_next;
                out_valid_reg <= 1'b1;
                out_byte_reg  <= q_item.data;
                out_kind_reg  <= kind_next;
                out_hdr_reg   <= hdr_next;
                out_class_reg <= out_class_next;
                out_tag_reg   <= tnum_next;
                out_len_reg   <= vlen_next;
                out_rend_reg  <= rend_next;
                out_err_reg   <= err_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output channel.
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.byte_out     = out_byte_reg;
    assign out_ch.byte_kind    = out_kind_reg;
    assign out_ch.header_done  = out_hdr_reg;
    assign out_ch.tag_class    = out_class_reg;
    assign out_ch.tag_number   = out_tag_reg;
    assign out_ch.value_length = out_len_reg;
    assign out_ch.record_end   = out_rend_reg;
    assign out_ch.error_code   = out_err_reg;

    // The last byte of a buffer always leaves the engine idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_item.last) |=> (phase_reg == PH_IDLE && val_left_reg == '0))
        else $error("engine not idle after end of buffer");

    // A header only completes on a length byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_hdr_reg) |-> (out_kind_reg == tsp_pkg::KIND_LENGTH))
        else $error("header done on a byte that is not a length byte");

    // A record only ends on a length or value byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rend_reg) |->
            (out_kind_reg == tsp_pkg::KIND_LENGTH || out_kind_reg == tsp_pkg::KIND_VALUE))
        else $error("record end on a tag or discarded byte");

endmodule

// ===== design/tlv_stream_parser_unit.sv =====
// ----------------------------------------------------------------------------
// TLV stream parser unit
// Labels each byte of a stream of back-to-back tag-length-value records and
// reports decoded tag, length, record boundaries and errors.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                         Transaction
//  in_ch    in   data_byte, buffer_end                           one raw byte
//  out_ch   out  byte_out, byte_kind, header_done, tag_class,    one labeled byte
//                tag_number, value_length, record_end, error_code
//
// One byte per clock cycle sustained while the output is not stalled. An
// accepted byte is written into the queue, then the engine takes it and
// registers its result in the output register.
// A two-entry queue between the front end and the engine absorbs output
// stalls; with the output register that holds up to three bytes in flight,
// and input ready drops only when that queue is full.
// Reset is asynchronous and active low and leaves the parser idle, waiting
// for the first tag byte; no clearing pass is needed.
//
module tlv_stream_parser_unit (
    input  logic      clk,
    input  logic      rst_n,
    tsp_in_if.sink    in_ch,
    tsp_out_if.source out_ch
);

    logic            q_valid;
    logic            q_ready;
    tsp_pkg::item_t  q_item;

    // Front end: accept, classify and queue bytes.
    tsp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_ready (q_ready)
    );

    // Parse engine: record phases and the result register.
    tsp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_ready (q_ready),
        .out_ch  (out_ch)
    );

endmodule

// ===== test/tlv_parse_checker.sv =====
// ----------------------------------------------------------------------------
// TLV stream parser checker
// Watches both channels of the parser. Every raw byte taken in is run through
// a behavioral copy of the parse rules, and the labeled byte it should produce
// is queued. Every labeled byte that leaves the block is compared, field by
// field, with the oldest queued one.
// ----------------------------------------------------------------------------
module tlv_parse_checker (
    input  logic clk,
    input  logic rst_n,
    tsp_in_if    in_mon,
    tsp_out_if   out_mon,
    output int   mismatch_count,
    output int   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Where the parser stands within the current record.
    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_TAG_EXT,
        PARSE_LEN_FIRST,
        PARSE_LEN_EXT,
        PARSE_VALUE,
        PARSE_DISCARD
    } parse_phase_t;

    // One labeled byte as the block should report it.
    typedef struct packed {
        logic [tsp_pkg::BYTE_W-1:0]  byte_out;
        logic [tsp_pkg::KIND_W-1:0]  byte_kind;
        logic                        header_done;
        logic [tsp_pkg::CLASS_W-1:0] tag_class;
        logic [tsp_pkg::TAG_W-1:0]   tag_number;
        logic [tsp_pkg::LEN_W-1:0]   value_length;
        logic                        record_end;
        logic [tsp_pkg::ERR_W-1:0]   error_code;
    } labeled_byte_t;

    // Parse state of the behavioral copy.
    parse_phase_t                phase;
    logic [tsp_pkg::TAG_W-1:0]   tag_acc;
    int unsigned                 tag_ext_seen;
    logic [tsp_pkg::CLASS_W-1:0] class_q;
    int unsigned                 len_bytes_left;
    logic [tsp_pkg::LEN_W-1:0]   len_acc;
    logic [tsp_pkg::LEN_W-1:0]   value_left;

    labeled_byte_t labeled_q[$];

    function automatic void clear_parse_state();
        phase          = PARSE_IDLE;
        tag_acc        = '0;
        tag_ext_seen   = 0;
        class_q        = '0;
        len_bytes_left = 0;
        len_acc        = '0;
        value_left     = '0;
    endfunction

    // Labels one raw byte and advances the parse state.
    function automatic labeled_byte_t label_byte(input logic [7:0] b, input logic is_last);
        labeled_byte_t             res;
        logic                      header_now;
        logic [tsp_pkg::ERR_W-1:0] err;
        res        = '0;
        header_now = 1'b0;
        err        = tsp_pkg::ERR_NONE;
        res.byte_out = b;

        case (phase)
            PARSE_IDLE:
            begin
                res.byte_kind = tsp_pkg::KIND_TAG;
                class_q = b[7:5];
                if (!b[4])
                begin
                    tag_acc = {{(tsp_pkg::TAG_W-4){1'b0}}, b[3:0]};
                    phase   = PARSE_LEN_FIRST;
                end
                else
                begin
                    tag_acc      = '0;
                    tag_ext_seen = 0;
                    phase        = PARSE_TAG_EXT;
                end
            end
            PARSE_TAG_EXT:
            begin
                res.byte_kind = tsp_pkg::KIND_TAG;
                tag_acc = {tag_acc[tsp_pkg::TAG_W-8:0], b[6:0]};
                tag_ext_seen++;
                if (b[7])
                    phase = PARSE_LEN_FIRST;
                else if (tag_ext_seen >= tsp_pkg::MAX_TAG_EXT_BYTES)
                begin
                    err   = tsp_pkg::ERR_TAG_LONG;
                    phase = PARSE_DISCARD;
                end
            end
            PARSE_LEN_FIRST:
            begin
                res.byte_kind = tsp_pkg::KIND_LENGTH;
                if (!b[7])
                begin
                    len_acc    = {{(tsp_pkg::LEN_W-8){1'b0}}, b};
                    header_now = 1'b1;
                end
                else if (b[6:0] == 7'd0)
                begin
                    len_acc    = '0;
                    header_now = 1'b1;
                end
                else if (b[6:0] > tsp_pkg::MAX_LENGTH_BYTES)
                begin
                    err   = tsp_pkg::ERR_LEN_LONG;
                    phase = PARSE_DISCARD;
                end
                else
                begin
                    len_acc        = '0;
                    len_bytes_left = b[6:0];
                    phase          = PARSE_LEN_EXT;
                end
            end
            PARSE_LEN_EXT:
            begin
                res.byte_kind = tsp_pkg::KIND_LENGTH;
                len_acc = {len_acc[tsp_pkg::LEN_W-9:0], b};
                if (len_bytes_left > 0)
                    len_bytes_left--;
                if (len_bytes_left == 0)
                    header_now = 1'b1;
            end
            PARSE_VALUE:
            begin
                res.byte_kind = tsp_pkg::KIND_VALUE;
                if (value_left != 0)
                    value_left--;
                if (value_left == 0)
                begin
                    res.record_end = 1'b1;
                    phase          = PARSE_IDLE;
                end
            end
            default:
            begin
                res.byte_kind = tsp_pkg::KIND_DISCARD;
            end
        endcase

        // The header is complete: report it and move on to the value bytes.
        if (header_now)
        begin
            res.header_done  = 1'b1;
            res.tag_number   = tag_acc;
            res.value_length = len_acc;
            if (len_acc == 0)
            begin
                res.record_end = 1'b1;
                phase          = PARSE_IDLE;
            end
            else
            begin
                value_left = len_acc;
                phase      = PARSE_VALUE;
            end
        end

        res.tag_class = (res.byte_kind == tsp_pkg::KIND_DISCARD) ? '0 : class_q;

        // A buffer that stops inside a record is reported as truncated.
        if (is_last)
        begin
            if (err == tsp_pkg::ERR_NONE && phase != PARSE_IDLE && phase != PARSE_DISCARD)
                err = tsp_pkg::ERR_TRUNCATED;
            clear_parse_state();
        end
        res.error_code = err;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Predict on each accepted raw byte, compare on each accepted labeled byte.
    always @(posedge clk or negedge rst_n)
    begin
        labeled_byte_t want;
        if (!rst_n)
        begin
            clear_parse_state();
            labeled_q.delete();
            mismatch_count = 0;
            pending_count  = 0;
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
                labeled_q.push_back(label_byte(in_mon.data_byte, in_mon.buffer_end));
            if (out_mon.valid && out_mon.ready)
            begin
                if (labeled_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none, actual byte 0x%0h",
                             $time, out_mon.byte_out);
                    mismatch_count++;
                end
                else
                begin
                    want = labeled_q.pop_front();
                    check_field("byte_out",     want.byte_out,     out_mon.byte_out);
                    check_field("byte_kind",    want.byte_kind,    out_mon.byte_kind);
                    check_field("header_done",  want.header_done,  out_mon.header_done);
                    check_field("tag_class",    want.tag_class,    out_mon.tag_class);
                    check_field("tag_number",   want.tag_number,   out_mon.tag_number);
                    check_field("value_length", want.value_length, out_mon.value_length);
                    check_field("record_end",   want.record_end,   out_mon.record_end);
                    check_field("error_code",   want.error_code,   out_mon.error_code);
                end
            end
            pending_count = labeled_q.size();
        end
    end

endmodule

// ===== test/tb_tlv_stream_parser_unit.sv =====
// ----------------------------------------------------------------------------
// TLV stream parser unit testbench
// Feeds the parser with buffers of TLV records: a short directed set for the
// header limits and error cases, then random well-formed, broken and noise
// buffers. Both channels idle and stall at random; a separate checker
// predicts and compares every labeled byte.
// ----------------------------------------------------------------------------
module tb_tlv_stream_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 1600;
    localparam int HOLD_AT_ITEM  = 500;
    localparam int DRAIN_AT_ITEM = 1100;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 3000;
    localparam int DRAIN_CYCLES  = 10;

    logic clk = 1'b0;
    logic rst_n;

    tsp_in_if  in_ch();
    tsp_out_if out_ch();

    int mismatches;
    int pending;

    tlv_stream_parser_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    tlv_parse_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_mon         (in_ch),
        .out_mon        (out_ch),
        .mismatch_count (mismatches),
        .pending_count  (pending)
    );

    // Clock generation.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sender pacing and the raw bytes of the buffer being built.
    int         burst_left = 0;
    int         gap_max    = 0;
    int         burst_max  = 1;
    int         sent_items = 0;
    logic [7:0] buffer_q[$];

    // Receiver: a randomly chosen stall style, plus one long hold.
    int          rx_cycle  = 0;
    int          rx_style  = 0;
    logic [15:0] rx_pattern = 16'hFFFF;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 64 == 0)
        begin
            rx_style   = $urandom_range(0, 3);
            rx_pattern = 16'($urandom);
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (!hold_done && sent_items >= HOLD_AT_ITEM)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            case (rx_style)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= 1'($urandom_range(0, 1));
                2:       out_ch.ready <= rx_pattern[rx_cycle % 16];
                default: out_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Offers one raw byte, with a random gap at the start of each burst.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        @(negedge clk);
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.buffer_end <= is_last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        burst_left--;
        sent_items++;
    endtask

    // Sends the built buffer, marking its final byte, and empties it.
    task automatic send_buffer();
        int i;
        for (i = 0; i < buffer_q.size(); i++)
            send_byte(buffer_q[i], i == buffer_q.size() - 1);
        buffer_q.delete();
    endtask

    // Stops offering and waits until every labeled byte has come out.
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    // Tag: short form when ext_bytes is zero, else 7-bit groups, most
    // significant first. Without a stop bit the tag never ends.
    task automatic add_tag(input logic [2:0] cls, input int ext_bytes,
                           input logic [27:0] number, input bit with_stop);
        int         i;
        logic [6:0] grp;
        if (ext_bytes == 0)
            buffer_q.push_back({cls, 1'b0, number[3:0]});
        else
        begin
            buffer_q.push_back({cls, 1'b1, 4'($urandom)});
            for (i = ext_bytes - 1; i >= 0; i--)
            begin
                grp = 7'(number >> (7 * i));
                buffer_q.push_back({(i == 0) && with_stop, grp});
            end
        end
    endtask

    // Length: a single byte when count is zero, else 0x8n and n bytes.
    task automatic add_length(input logic [31:0] len, input int count);
        int i;
        if (count == 0)
            buffer_q.push_back(len[7:0]);
        else
        begin
            buffer_q.push_back(8'h80 | 8'(count));
            for (i = count - 1; i >= 0; i--)
                buffer_q.push_back(8'(len >> (8 * i)));
        end
    endtask

    // One well-formed record with random content.
    task automatic add_record();
        int          sel;
        int          count;
        logic [31:0] len;
        add_tag(3'($urandom), $urandom_range(0, tsp_pkg::MAX_TAG_EXT_BYTES),
                28'($urandom), 1'b1);
        sel = $urandom_range(0, 99);
        if (sel < 8)
        begin
            len = 0;
            buffer_q.push_back(8'h80);
        end
        else
        begin
            len = (sel < 80) ? $urandom_range(0, 20) : $urandom_range(0, 300);
            if (len < 128 && $urandom_range(0, 1) == 0)
                count = 0;
            else
                count = $urandom_range((len < 256) ? 1 : 2, tsp_pkg::MAX_LENGTH_BYTES);
            add_length(len, count);
        end
        repeat (len) buffer_q.push_back(8'($urandom));
    endtask

    task automatic add_noise(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) buffer_q.push_back(8'($urandom));
    endtask

    // One random buffer: mostly well-formed records, the rest broken or noise.
    task automatic build_random_buffer();
        int sel;
        int keep;
        sel = $urandom_range(0, 99);
        if (sel < 70)
        begin
            repeat ($urandom_range(1, 4)) add_record();
            if ($urandom_range(0, 9) == 0)
            begin
                keep = $urandom_range(1, buffer_q.size());
                while (buffer_q.size() > keep)
                    void'(buffer_q.pop_back());
            end
        end
        else if (sel < 80)
        begin
            if ($urandom_range(0, 1) == 0)
                add_record();
            add_tag(3'($urandom), tsp_pkg::MAX_TAG_EXT_BYTES, 28'($urandom), 1'b0);
            add_noise(0, 6);
        end
        else if (sel < 88)
        begin
            add_tag(3'($urandom), 0, 28'($urandom), 1'b1);
            buffer_q.push_back(8'h80 |
                8'($urandom_range(tsp_pkg::MAX_LENGTH_BYTES + 1, 127)));
            add_noise(0, 6);
        end
        else if (sel < 93)
        begin
            // Huge length: the buffer ends long before the value does.
            add_tag(3'($urandom), $urandom_range(0, 2), 28'($urandom), 1'b1);
            add_length($urandom, tsp_pkg::MAX_LENGTH_BYTES);
            add_noise(1, 8);
        end
        else
            add_noise(1, 30);
    endtask

    // Stimulus and verdict.
    initial
    begin
        bit held;
        bit drained;
        held    = 1'b0;
        drained = 1'b0;

        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = 8'h00;
        in_ch.buffer_end = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed buffers, sent back to back without gaps.
        gap_max   = 0;
        burst_max = 64;
        // Short tag with a zero one-byte length.
        buffer_q = '{8'hE5, 8'h00};
        send_buffer();
        // Largest long tag, then the zero count byte.
        buffer_q = '{8'h3F, 8'h7F, 8'h7F, 8'h7F, 8'hFF, 8'h80};
        send_buffer();
        // Tag without a stop bit, then discarded bytes.
        buffer_q = '{8'h10, 8'h01, 8'h02, 8'h03, 8'h04, 8'hAA, 8'h55};
        send_buffer();
        // Length count over the limit on the final byte of the buffer.
        buffer_q = '{8'h02, 8'h85};
        send_buffer();
        // Largest four-byte length, cut short in the value.
        buffer_q = '{8'h04, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_buffer();
        drain();

        // Random buffers under changing sender pacing.
        while (sent_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        gap_max   = 0;
                        burst_max = 64;
                    end
                    1:
                    begin
                        gap_max   = 3;
                        burst_max = 8;
                    end
                    default:
                    begin
                        gap_max   = 10;
                        burst_max = 3;
                    end
                endcase
            end
            // The receiver starts its long hold here; keep offering bytes.
            if (!held && sent_items >= HOLD_AT_ITEM)
            begin
                held    = 1'b1;
                gap_max = 0;
            end
            if (!drained && sent_items >= DRAIN_AT_ITEM)
            begin
                drained = 1'b1;
                drain();
            end
            build_random_buffer();
            send_buffer();
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tsp_pkg.sv
design/tsp_in_if.sv
design/tsp_out_if.sv
design/tsp_front.sv
design/tsp_back.sv
design/tlv_stream_parser_unit.sv
test/tlv_parse_checker.sv
test/tb_tlv_stream_parser_unit.sv
